// File: rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg: shared constants for the 3x3 matrix inverse
// element count and default formats
// ----------------------------------------------------------------------------
package mi3_pkg;
    localparam int unsigned DATA_WIDTH_DEF = 32;
    localparam int unsigned FRAC_BITS_DEF  = 16;
    localparam int unsigned N_ELEM         = 9;
endpackage

// File: rtl/matrix_inverse_3x3.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: 3x3 inverse by adjugate over determinant
// stages: 4 in the front, DATA_WIDTH+3 in the divider, with a two-entry queue between them
// throughput: one matrix word per cycle while m_axis_tready is high, the divider is fully pipelined
// reset: synchronous active low, clears valid flags and the queue pointers and count only
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
    parameter int unsigned DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
    parameter int unsigned FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // m00 m01 m02 m10 m11 m12 m20 m21 m22 from the lowest bit up
    input  logic [9*DATA_WIDTH-1:0]   s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // inv00 .. inv22 from the lowest bit up
    output logic [9*DATA_WIDTH-1:0]   m_axis_tdata,
    // singular
    output logic                      m_axis_tuser
);
    import mi3_pkg::*;
    localparam int unsigned CW = 2*DATA_WIDTH+1;
    localparam int unsigned DTW = 3*DATA_WIDTH+3;
    localparam int unsigned QW = 9*CW + DTW;

    logic signed [DATA_WIDTH-1:0] m [9];
    logic signed [CW-1:0] f_adj [9], b_adj [9];
    logic signed [DTW-1:0] f_det, b_det;
    logic f_v, f_r, b_v, b_r;
    logic [QW-1:0] q_in, q_out;
    logic [DATA_WIDTH-1:0] inv [9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            m[k] = s_axis_tdata[k*DATA_WIDTH +: DATA_WIDTH];
            q_in[k*CW +: CW] = f_adj[k];
            b_adj[k] = q_out[k*CW +: CW];
            m_axis_tdata[k*DATA_WIDTH +: DATA_WIDTH] = inv[k];
        end
        q_in[9*CW +: DTW] = f_det;
        b_det = q_out[9*CW +: DTW];
    end

    // front: cofactors and determinant
    mi3_front #(.DW(DATA_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_m(m), .o_valid(f_v), .i_ready(f_r), .o_adj(f_adj), .o_det(f_det));

    // queue decouples front and back stalls
    mi3_queue #(.W(QW)) u_queue (
        .i_clk, .i_rst_n, .i_valid(f_v), .o_ready(f_r), .i_data(q_in),
        .o_valid(b_v), .i_ready(b_r), .o_data(q_out));

    // back: division, rounding, saturation
    mi3_back #(.DW(DATA_WIDTH), .FB(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(b_v), .o_ready(b_r), .i_adj(b_adj),
        .i_det(b_det), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_inv(inv), .o_singular(m_axis_tuser));
endmodule

// File: rtl/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front: cofactor and determinant pipeline
// forms the adjugate and the determinant, one matrix per cycle, stalls as a whole
// ----------------------------------------------------------------------------
module mi3_front #(
    parameter int unsigned DW = mi3_pkg::DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [DW-1:0]        i_m [9],
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [2*DW:0]        o_adj [9],
    output logic signed [3*DW+2:0]      o_det
);
    import mi3_pkg::*;
    localparam int unsigned CW = 2*DW+1;
    localparam int unsigned DTW = 3*DW+3;
    localparam int unsigned PAW = 2*DW;
    localparam int unsigned PW = 2*DW+1;   // element times one half of a cofactor
    localparam int unsigned SW = 2*DW+3;

    // stage 1: products for cofactors
    logic                      r_v1, r_v2, r_v3, r_v4;
    logic signed [2*DW-1:0]    r_pa [9];
    logic signed [2*DW-1:0]    r_pb [9];
    logic signed [DW-1:0]      r_m1 [3];
    logic signed [CW-1:0]      r_adj2 [9];
    logic signed [DW-1:0]      r_m2 [3];
    logic signed [PW-1:0]      r_ph3 [3];
    logic signed [PW-1:0]      r_pl3 [3];
    logic signed [CW-1:0]      r_adj3 [9];
    logic signed [SW-1:0]      r_sh4, r_sl4;
    logic signed [CW-1:0]      r_adj4 [9];
    logic                      adv;

    assign adv     = !r_v4 || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pa[0] <= PAW'(i_m[4]) * PAW'(i_m[8]); r_pb[0] <= PAW'(i_m[5]) * PAW'(i_m[7]);
            r_pa[1] <= PAW'(i_m[2]) * PAW'(i_m[7]); r_pb[1] <= PAW'(i_m[1]) * PAW'(i_m[8]);
            r_pa[2] <= PAW'(i_m[1]) * PAW'(i_m[5]); r_pb[2] <= PAW'(i_m[2]) * PAW'(i_m[4]);
            r_pa[3] <= PAW'(i_m[5]) * PAW'(i_m[6]); r_pb[3] <= PAW'(i_m[3]) * PAW'(i_m[8]);
            r_pa[4] <= PAW'(i_m[0]) * PAW'(i_m[8]); r_pb[4] <= PAW'(i_m[2]) * PAW'(i_m[6]);
            r_pa[5] <= PAW'(i_m[2]) * PAW'(i_m[3]); r_pb[5] <= PAW'(i_m[0]) * PAW'(i_m[5]);
            r_pa[6] <= PAW'(i_m[3]) * PAW'(i_m[7]); r_pb[6] <= PAW'(i_m[4]) * PAW'(i_m[6]);
            r_pa[7] <= PAW'(i_m[1]) * PAW'(i_m[6]); r_pb[7] <= PAW'(i_m[0]) * PAW'(i_m[7]);
            r_pa[8] <= PAW'(i_m[0]) * PAW'(i_m[4]); r_pb[8] <= PAW'(i_m[1]) * PAW'(i_m[3]);
            r_m1 <= '{i_m[0], i_m[1], i_m[2]};
            for (int k = 0; k < 9; k++)
                r_adj2[k] <= CW'(r_pa[k]) - CW'(r_pb[k]);
            r_m2 <= r_m1;
            // element times upper signed half and lower unsigned half of its cofactor
            for (int k = 0; k < 3; k++) begin
                r_ph3[k] <= PW'(r_m2[k]) * PW'($signed(r_adj2[3*k][CW-1:DW]));
                r_pl3[k] <= PW'(r_m2[k]) * PW'($signed({1'b0, r_adj2[3*k][DW-1:0]}));
            end
            r_adj3 <= r_adj2;
            r_sh4 <= SW'(r_ph3[0]) + SW'(r_ph3[1]) + SW'(r_ph3[2]);
            r_sl4 <= SW'(r_pl3[0]) + SW'(r_pl3[1]) + SW'(r_pl3[2]);
            r_adj4 <= r_adj3;
        end
    end

    assign o_adj = r_adj4;
    assign o_det = (DTW'(r_sh4) << DW) + DTW'(r_sl4);
endmodule

// File: rtl/mi3_queue.sv
// ----------------------------------------------------------------------------
// mi3_queue: two-entry queue between the front and the back
// decouples the stall of the divider from the cofactor pipeline
// ----------------------------------------------------------------------------
module mi3_queue #(
    parameter int unsigned W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         wr, rd;
    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    assign o_data = r_mem[r_rp];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule

// File: rtl/mi3_back.sv
// ----------------------------------------------------------------------------
// mi3_back: pipelined restoring divider with rounding and saturation
// one quotient bit per stage for all nine elements at once
// ----------------------------------------------------------------------------
module mi3_back #(
    parameter int unsigned DW = mi3_pkg::DATA_WIDTH_DEF,
    parameter int unsigned FB = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [2*DW:0]   i_adj [9],
    input  logic signed [3*DW+2:0] i_det,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [DW-1:0]          o_inv [9],
    output logic                   o_singular
);
    import mi3_pkg::*;
    // quotient bits kept: DW+1 plus a round bit; higher ones mean saturation
    localparam int unsigned QB = DW + 2;
    localparam int unsigned NW = 2*DW + 2*FB + 1;  // magnitude of cof << 2F
    localparam int unsigned DMW = 3*DW + 3;
    localparam int unsigned NS = QB;
    localparam int unsigned RW = NW + 1;           // remainder of the doubled numerator
    localparam int unsigned CMPW = DMW + QB;

    logic                   r_v    [NS+1];
    logic [DMW-1:0]         r_d    [NS+1];
    logic [RW-1:0]          r_r    [NS+1][9];
    logic [QB-1:0]          r_q    [NS+1][9];
    logic                   r_neg  [NS+1][9];
    logic                   r_ovf  [NS+1][9];
    logic                   r_z    [NS+1];
    logic                   adv;

    assign adv = !r_v[NS] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v[NS];

    // entry stage: magnitudes, then an overflow test of the numerator against the shifted divisor
    logic [DMW-1:0] dmag;
    logic [2*DW:0]  cm [9];
    always_comb begin
        dmag = i_det[DMW-1] ? DMW'(-i_det) : DMW'(i_det);
        for (int k = 0; k < 9; k++)
            cm[k] = i_adj[k][2*DW] ? (2*DW+1)'(-i_adj[k]) : (2*DW+1)'(i_adj[k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) r_v[s] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= NS; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d[0] <= dmag;
            r_z[0] <= (i_det == '0);
            for (int k = 0; k < 9; k++) begin
                logic [NW-1:0] nn;
                nn = {cm[k], {(2*FB){1'b0}}};
                r_neg[0][k] <= i_adj[k][2*DW] ^ i_det[DMW-1];
                // floor(2n/d) needs more than QB bits iff n >= d<<(QB-1)
                r_ovf[0][k] <= CMPW'(nn) >= (CMPW'(dmag) << (QB-1));
                r_r[0][k] <= {nn, 1'b0};
                r_q[0][k] <= '0;
            end
            for (int s = 1; s <= NS; s++) begin
                r_d[s] <= r_d[s-1];
                r_z[s] <= r_z[s-1];
                for (int k = 0; k < 9; k++) begin
                    logic [CMPW-1:0] part;
                    logic [CMPW-1:0] dsh;
                    logic            qb;
                    // quotient bit QB-s: try to take d shifted to that place
                    part = CMPW'(r_r[s-1][k]);
                    dsh  = CMPW'(r_d[s-1]) << (QB-s);
                    qb   = part >= dsh;
                    r_r[s][k] <= qb ? RW'(part - dsh) : r_r[s-1][k];
                    r_neg[s][k] <= r_neg[s-1][k];
                    r_ovf[s][k] <= r_ovf[s-1][k];
                    r_q[s][k] <= {r_q[s-1][k][QB-2:0], qb};
                end
            end
        end
    end

    // output: r_q holds floor(2n/d); round up when its low bit is set
    always_comb begin
        o_singular = r_z[NS];
        for (int k = 0; k < 9; k++) begin
            logic [QB:0] mag;
            logic [QB:0] lim;
            mag = ((QB+1)'(r_q[NS][k]) + (QB+1)'(1)) >> 1;
            lim = (QB+1)'(1) << (DW-1);
            if (r_z[NS]) o_inv[k] = '0;
            else if (r_neg[NS][k])
                o_inv[k] = (r_ovf[NS][k] || mag > lim) ? DW'(lim) : DW'(-mag);
            else
                o_inv[k] = (r_ovf[NS][k] || mag > lim - 1) ? DW'(lim - 1) : DW'(mag);
        end
    end
endmodule

// File: dv/matrix_inverse_3x3_test.sv
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_test: self-checking bench for the 3x3 matrix inverse
// streams directed and random matrices with random idle bursts on both sides
// and checks each result word against a typed inverse or an exact wide-integer predictor
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_test;
    import mi3_pkg::*;

    localparam int DW       = DATA_WIDTH_DEF;
    localparam int FB       = FRAC_BITS_DEF;
    localparam int N_RAND   = 1600;
    localparam int CALM     = 200;      // last words sent and taken without idling
    localparam int LIMIT    = 400000;
    localparam int DRAIN    = 2 * DW + 40;
    localparam logic [DW-1:0] ONE  = 1 << FB;
    localparam logic [DW-1:0] HALF = 1 << (FB - 1);
    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    typedef logic [N_ELEM*DW-1:0] t_mat;
    typedef struct packed {
        t_mat inv;
        logic singular;
    } t_inv_word;

    // directed row: matrix, and the typed inverse where it is obvious
    typedef struct {
        t_mat      m;
        bit        typed;
        t_inv_word want;
    } t_stim_row;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [N_ELEM*DW-1:0] s_axis_tdata = '0;  // m00 m01 m02 m10 .. m22 from the lowest bit up
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [N_ELEM*DW-1:0] m_axis_tdata;       // inv00 inv01 .. inv22 from the lowest bit up
    logic m_axis_tuser;                       // singular

    t_inv_word pending_inverses[$];
    int  n_errors = 0;
    int  cycle = 0;
    bit  calm = 0;

    matrix_inverse_3x3 u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // exact inverse: adjugate entries over the determinant, round half away, saturate
    function automatic logic [DW-1:0] div_round_sat(logic signed [191:0] cof,
                                                    logic signed [191:0] det);
        logic [191:0] num, den, q, r;
        logic         neg;
        neg = cof[191] ^ det[191];
        num = (cof[191] ? -cof : cof) << (2 * FB);
        den = det[191] ? -det : det;
        q   = num / den;
        r   = num % den;
        if ((r << 1) >= den) q = q + 1;
        if (neg) return (q > {1'b0, SMIN}) ? SMIN : -q[DW-1:0];
        return (q > SMAX) ? SMAX : q[DW-1:0];
    endfunction

    function automatic t_inv_word invert(t_mat m);
        logic signed [191:0] e[9];
        logic signed [191:0] adj[9];
        logic signed [191:0] det;
        t_inv_word res;
        for (int i = 0; i < 9; i++) e[i] = $signed(m[i*DW +: DW]);
        adj[0] = e[4]*e[8] - e[5]*e[7];
        adj[1] = e[2]*e[7] - e[1]*e[8];
        adj[2] = e[1]*e[5] - e[2]*e[4];
        adj[3] = e[5]*e[6] - e[3]*e[8];
        adj[4] = e[0]*e[8] - e[2]*e[6];
        adj[5] = e[2]*e[3] - e[0]*e[5];
        adj[6] = e[3]*e[7] - e[4]*e[6];
        adj[7] = e[1]*e[6] - e[0]*e[7];
        adj[8] = e[0]*e[4] - e[1]*e[3];
        det = e[0]*adj[0] + e[1]*adj[3] + e[2]*adj[6];
        res = '0;
        if (det == 0) begin
            res.singular = 1'b1;
            return res;
        end
        for (int i = 0; i < 9; i++) res.inv[i*DW +: DW] = div_round_sat(adj[i], det);
        return res;
    endfunction

    function automatic t_mat diag(logic [DW-1:0] a, logic [DW-1:0] b, logic [DW-1:0] c);
        t_mat m;
        m = '0;
        m[0 +: DW] = a;
        m[4*DW +: DW] = b;
        m[8*DW +: DW] = c;
        return m;
    endfunction

    function automatic t_mat fill(logic [DW-1:0] v);
        return {N_ELEM{v}};
    endfunction

    function automatic logic [DW-1:0] rnd_elem(int span);
        return DW'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic t_mat rnd_matrix();
        t_mat m;
        int   kind;
        int   span;
        kind = $urandom_range(0, 99);
        span = (kind < 60) ? 4 * (1 << FB) : 1 << $urandom_range(0, 30);
        for (int i = 0; i < 9; i++) m[i*DW +: DW] = rnd_elem(span);
        if (kind >= 85) begin
            m = '0;
            for (int i = 0; i < 9; i++) m[i*DW +: DW] = {$urandom};
        end else if (kind >= 70) begin
            // singular: copy a row, or clear a column
            if ($urandom_range(0, 1))
                m[6*DW +: 3*DW] = m[0 +: 3*DW];
            else
                for (int r = 0; r < 3; r++) m[(3*r + 1)*DW +: DW] = '0;
        end else if (kind >= 60) begin
            m = diag({$urandom}, {$urandom}, rnd_elem(8));
        end
        return m;
    endfunction

    // one matrix word onto the input stream, with an optional idle burst first
    task automatic send_matrix(t_mat m, bit typed, t_inv_word want);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= m;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_inverses.push_back(typed ? want : invert(m));
    endtask

    // output side: random backpressure bursts, compare each taken word
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_inverses.size() == 0) begin
                $error("unexpected result word");
                n_errors++;
            end else begin
                t_inv_word exp_w;
                exp_w = pending_inverses.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_axis_tdata[i*DW +: DW] !== exp_w.inv[i*DW +: DW]) begin
                        $error("inv%0d%0d: expected %h, got %h", i / 3, i % 3,
                               exp_w.inv[i*DW +: DW], m_axis_tdata[i*DW +: DW]);
                        n_errors++;
                    end
                if (m_axis_tuser !== exp_w.singular) begin
                    $error("singular: expected %b, got %b", exp_w.singular, m_axis_tuser);
                    n_errors++;
                end
            end
        end
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left    <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    t_stim_row directed[$];
    t_inv_word none;
    t_inv_word w;

    initial begin
        none = '0;
        // singular cases and easy inverses typed in directly
        w = '0; w.singular = 1'b1;
        directed.push_back('{fill('0), 1, w});
        directed.push_back('{fill(ONE), 1, w});
        directed.push_back('{fill(SMAX), 1, w});
        directed.push_back('{fill(SMIN), 1, w});
        directed.push_back('{fill({DW{1'b1}}), 1, w});
        w = '0; w.inv = diag(ONE, ONE, ONE);
        directed.push_back('{diag(ONE, ONE, ONE), 1, w});
        w = '0; w.inv = diag(HALF, HALF, HALF);
        directed.push_back('{diag(2 * ONE, 2 * ONE, 2 * ONE), 1, w});
        w = '0; w.inv = diag(-ONE, -ONE, -ONE);
        directed.push_back('{diag(-ONE, -ONE, -ONE), 1, w});
        // one lsb on the diagonal saturates high, minus one lsb saturates low
        w = '0; w.inv = diag(SMAX, SMAX, SMAX);
        directed.push_back('{diag(1, 1, 1), 1, w});
        w = '0; w.inv = diag(SMIN, SMIN, SMIN);
        directed.push_back('{diag(-1, -1, -1), 1, w});
        // the rest go through the predictor
        directed.push_back('{diag(SMAX, SMAX, SMAX), 0, none});
        directed.push_back('{diag(SMIN, SMIN, SMIN), 0, none});
        directed.push_back('{diag(SMIN, SMAX, 1), 0, none});
        directed.push_back('{diag(3 * ONE, 3 * ONE, 3 * ONE), 0, none}); // rounding
        directed.push_back('{diag(SMIN, ONE, ONE), 0, none});            // exact minimum
        directed.push_back('{{SMAX, SMIN, 32'h5555_5555, 32'haaaa_aaaa, ONE,
                              -ONE, 32'h0001_2345, SMAX, SMIN}, 0, none});
        directed.push_back('{{ONE, 2 * ONE, 3 * ONE, DW'(0), ONE, 4 * ONE,
                              5 * ONE, 6 * ONE, DW'(0)}, 0, none});
        directed.push_back('{{2 * ONE, DW'(0), DW'(0), DW'(0), DW'(0), ONE,
                              DW'(0), ONE, DW'(0)}, 0, none}); // scaled permutation

        i_rst_n = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_matrix(directed[k].m, directed[k].typed, directed[k].want);
        for (int k = 0; k < N_RAND; k++) begin
            if (k == N_RAND - CALM) calm = 1;
            send_matrix(rnd_matrix(), 0, none);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_inverses.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
